FILE: rtl/sbc_pkg.sv
package sbc_pkg;

  localparam int CMD_W = 2;
  localparam int SEC_W = 15;
  localparam int ACT_W = 3;
  localparam int BLK_W = 2;
  localparam int OFF_W = 3;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_PARAM_ERR = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_SYNC  = 2'd2,
    CMD_OTHER = 2'd3
  } cmd_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREAD  = 3'd0,
    ACT_FREAD  = 3'd1,
    ACT_CWRITE = 3'd2,
    ACT_WBACK  = 3'd3,
    ACT_FILL   = 3'd4,
    ACT_DONE   = 3'd5
  } action_t;

  // Which block index drives the result and the boundary/dirty read port.
  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_HIT  = 2'd1,
    SEL_TGT  = 2'd2,
    SEL_IDX  = 2'd3
  } blk_sel_t;

  typedef struct packed {
    logic     capture;
    logic     tgt_hit;
    logic     tgt_free;
    logic     idx_clr;
    logic     idx_inc;
    logic     best_upd;
    logic     fill_wr;
    logic     dirty_set;
    logic     dirty_clr;
    logic     emit;
    action_t  action;
    blk_sel_t blk_sel;
    logic     status;
    logic     last;
  } sbc_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic hit;
    logic any_free;
    logic idx_last;
    logic cur_dirty;
    logic out_free;
  } sbc_stat_t;

endpackage

FILE: rtl/sbc_datapath.sv
module sbc_datapath
  import sbc_pkg::*;
#(
  parameter int NUM_BLOCKS        = 3,
  parameter int SECTORS_PER_BLOCK = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CMD_W-1:0] cmd,
  input  logic [SEC_W-1:0] sector,
  input  logic             final_sector,
  input  sbc_cmd_t         ctl,
  output sbc_stat_t        stat,
  output logic             res_valid,
  input  logic             res_ready,
  output action_t          res_action,
  output logic [BLK_W-1:0] res_block,
  output logic [SEC_W-1:0] res_flash_sector,
  output logic [OFF_W-1:0] res_offset,
  output logic             res_status,
  output logic             res_last,
  output logic             res_request_done
);

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LW = $clog2(SECTORS_PER_BLOCK);
  localparam int SH = SEC_W + LW;
  localparam int MW = SEC_W + 1;
  localparam int PW = SEC_W + MW;
  localparam logic [SEC_W:0]     SPB_EXT  = (SEC_W + 1)'(SECTORS_PER_BLOCK);
  localparam logic [IW-1:0]      LAST_IDX = IW'(NUM_BLOCKS - 1);
  localparam logic [MW-1:0]      RECIP    =
    MW'(((1 << SH) + SECTORS_PER_BLOCK - 1) / SECTORS_PER_BLOCK);
  localparam logic [2*SEC_W-1:0] SPB_MUL  = (2*SEC_W)'(SECTORS_PER_BLOCK);

  cmd_t                  cmd_r;
  logic [SEC_W-1:0]      sec_r;
  logic                  fin_r;
  logic [NUM_BLOCKS-1:0] valid;
  logic [NUM_BLOCKS-1:0] dirty;
  logic [SEC_W-1:0]      boundary [NUM_BLOCKS];
  logic [SEC_W-1:0]      quo;
  logic [IW-1:0]         idx;
  logic [IW-1:0]         tgt;
  logic [SEC_W-1:0]      best;

  logic [NUM_BLOCKS-1:0] hit_vec;
  logic [IW-1:0]         hit_idx;
  logic [IW-1:0]         free_idx;
  logic [IW-1:0]         blk;
  logic [SEC_W-1:0]      rd_bnd;
  logic [SEC_W-1:0]      nb;
  logic [SEC_W-1:0]      diff;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         quo_full;
  logic [2*SEC_W-1:0]    nb_full;
  logic [SEC_W-1:0]      sec_sel;
  logic [OFF_W-1:0]      off_sel;
  logic                  out_free;

  // Range compare per block; the sum is one bit wider so it cannot wrap.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      hit_vec[i] = valid[i] && (sec_r >= boundary[i]) &&
                   ({1'b0, sec_r} < ({1'b0, boundary[i]} + SPB_EXT));
      if (hit_vec[i]) begin
        hit_idx = IW'(i);
      end
      if (!valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    case (ctl.blk_sel)
      SEL_HIT: blk = hit_idx;
      SEL_TGT: blk = tgt;
      SEL_IDX: blk = idx;
      default: blk = '0;
    endcase
  end

  assign rd_bnd = boundary[blk];
  assign diff   = sec_r - rd_bnd;

  // Quotient by the block size through a rounded-up reciprocal, exact for
  // every sector number; the boundary is the quotient times the block size.
  assign prod     = {{MW{1'b0}}, sector} * {{SEC_W{1'b0}}, RECIP};
  assign quo_full = prod >> SH;
  assign nb_full  = {{SEC_W{1'b0}}, quo} * SPB_MUL;
  assign nb       = nb_full[SEC_W-1:0];

  assign out_free = !res_valid || res_ready;

  always_comb begin
    unique case (ctl.action) inside
      ACT_CREAD, ACT_CWRITE: begin
        sec_sel = sec_r;
        off_sel = OFF_W'(diff);
      end
      ACT_FREAD: begin
        sec_sel = sec_r;
        off_sel = '0;
      end
      ACT_WBACK: begin
        sec_sel = rd_bnd;
        off_sel = '0;
      end
      ACT_FILL: begin
        sec_sel = nb;
        off_sel = '0;
      end
      default: begin
        sec_sel = '0;
        off_sel = '0;
      end
    endcase
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.hit       = |hit_vec;
    stat.any_free  = ~&valid;
    stat.idx_last  = (idx == LAST_IDX);
    stat.cur_dirty = dirty[blk];
    stat.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      dirty     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (ctl.fill_wr) begin
        valid[tgt] <= 1'b1;
        dirty[tgt] <= 1'b0;
      end
      if (ctl.dirty_set) begin
        dirty[tgt] <= 1'b1;
      end
      if (ctl.dirty_clr) begin
        dirty[blk] <= 1'b0;
      end
      if (ctl.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= cmd_t'(cmd);
      sec_r <= sector;
      fin_r <= final_sector;
      quo   <= quo_full[SEC_W-1:0];
    end
    if (ctl.fill_wr) begin
      boundary[tgt] <= nb;
    end
    if (ctl.idx_clr) begin
      idx  <= '0;
      tgt  <= '0;
      best <= '0;
    end else begin
      if (ctl.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (ctl.best_upd && (rd_bnd > best)) begin
        best <= rd_bnd;
        tgt  <= idx;
      end
      if (ctl.tgt_hit) begin
        tgt <= hit_idx;
      end
      if (ctl.tgt_free) begin
        tgt <= free_idx;
      end
    end
    if (ctl.emit) begin
      res_action       <= ctl.action;
      res_block        <= BLK_W'(blk);
      res_flash_sector <= sec_sel;
      res_offset       <= off_sel;
      res_status       <= ctl.status;
      res_last         <= ctl.last;
      res_request_done <= ctl.last & fin_r;
    end
  end

endmodule

FILE: rtl/sbc_controller.sv
module sbc_controller
  import sbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  sbc_stat_t stat,
  output sbc_cmd_t  ctl
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_SCAN     = 8'b0000_0100,
    S_EVICT    = 8'b0000_1000,
    S_FILL     = 8'b0001_0000,
    S_CWRITE   = 8'b0010_0000,
    S_SYNC     = 8'b0100_0000,
    S_SYNC_END = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl         = '0;
    ctl.action  = ACT_DONE;
    ctl.blk_sel = SEL_ZERO;
    ctl.status  = STATUS_OK;
    item_ready  = 1'b0;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_READ: begin
            if (stat.hit) begin
              ctl.action  = ACT_CREAD;
              ctl.blk_sel = SEL_HIT;
            end else begin
              ctl.action  = ACT_FREAD;
            end
            if (stat.out_free) begin
              ctl.emit   = 1'b1;
              ctl.last   = 1'b1;
              state_next = S_IDLE;
            end
          end
          CMD_WRITE: begin
            if (stat.hit) begin
              ctl.tgt_hit = 1'b1;
              state_next  = S_CWRITE;
            end else if (stat.any_free) begin
              ctl.tgt_free = 1'b1;
              state_next   = S_FILL;
            end else begin
              ctl.idx_clr = 1'b1;
              state_next  = S_SCAN;
            end
          end
          CMD_SYNC: begin
            ctl.idx_clr = 1'b1;
            state_next  = S_SYNC;
          end
          CMD_OTHER: begin
            ctl.status = STATUS_PARAM_ERR;
            if (stat.out_free) begin
              ctl.emit   = 1'b1;
              ctl.last   = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN: begin
        ctl.blk_sel  = SEL_IDX;
        ctl.best_upd = 1'b1;
        ctl.idx_inc  = 1'b1;
        if (stat.idx_last) begin
          state_next = S_EVICT;
        end
      end
      S_EVICT: begin
        ctl.blk_sel = SEL_TGT;
        ctl.action  = ACT_WBACK;
        if (!stat.cur_dirty) begin
          state_next = S_FILL;
        end else if (stat.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        ctl.blk_sel = SEL_TGT;
        ctl.action  = ACT_FILL;
        if (stat.out_free) begin
          ctl.emit    = 1'b1;
          ctl.fill_wr = 1'b1;
          state_next  = S_CWRITE;
        end
      end
      S_CWRITE: begin
        ctl.blk_sel = SEL_TGT;
        ctl.action  = ACT_CWRITE;
        if (stat.out_free) begin
          ctl.emit      = 1'b1;
          ctl.dirty_set = 1'b1;
          ctl.last      = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SYNC: begin
        ctl.blk_sel = SEL_IDX;
        ctl.action  = ACT_WBACK;
        if (!stat.cur_dirty || stat.out_free) begin
          ctl.emit      = stat.cur_dirty;
          ctl.dirty_clr = stat.cur_dirty;
          ctl.idx_inc   = 1'b1;
          if (stat.idx_last) begin
            state_next = S_SYNC_END;
          end
        end
      end
      S_SYNC_END: begin
        if (stat.out_free) begin
          ctl.emit   = 1'b1;
          ctl.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/sector_block_cache_controller_unit.sv
// One command at a time; the next can be accepted once the last action is registered.
// Reset (rst, synchronous, active high) marks every block invalid and clean and empties
// the result register; block boundaries are not cleared and are read only for valid blocks.
module sector_block_cache_controller_unit
  import sbc_pkg::*;
#(
  parameter int NUM_BLOCKS        = 3,
  parameter int SECTORS_PER_BLOCK = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Command stream. One transaction is one sector command.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [14:0] sector, [15] zero fill
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  input  logic        s_axis_tlast,   // final_sector
  // Action stream. Each command yields one to four action transactions with three blocks.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] block, [16:2] flash_sector, [19:17] offset,
                                      // [23:20] zero fill
  output logic [4:0]  m_axis_tuser,   // [2:0] action, [3] status, [4] request_done
  output logic        m_axis_tlast    // last action of the command
);

  // The controller sequences each command through dispatch, victim scan,
  // writeback, fill and cache write steps. The datapath keeps the tag state
  // (valid, dirty and boundary per block), the reciprocal multiply that rounds
  // the sector down to its block boundary, and the registered result stage. The
  // result register lets a new command be accepted while the final action of
  // the previous one still waits downstream.

  sbc_cmd_t         ctl;
  sbc_stat_t        stat;
  action_t          res_action;
  logic [BLK_W-1:0] res_block;
  logic [SEC_W-1:0] res_flash_sector;
  logic [OFF_W-1:0] res_offset;
  logic             res_status;
  logic             res_request_done;

  sbc_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s_axis_tvalid),
    .item_ready (s_axis_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  sbc_datapath #(
    .NUM_BLOCKS        (NUM_BLOCKS),
    .SECTORS_PER_BLOCK (SECTORS_PER_BLOCK)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (s_axis_tuser),
    .sector           (s_axis_tdata[SEC_W-1:0]),
    .final_sector     (s_axis_tlast),
    .ctl              (ctl),
    .stat             (stat),
    .res_valid        (m_axis_tvalid),
    .res_ready        (m_axis_tready),
    .res_action       (res_action),
    .res_block        (res_block),
    .res_flash_sector (res_flash_sector),
    .res_offset       (res_offset),
    .res_status       (res_status),
    .res_last         (m_axis_tlast),
    .res_request_done (res_request_done)
  );

  assign m_axis_tdata = {4'b0000, res_offset, res_flash_sector, res_block};
  assign m_axis_tuser = {res_request_done, res_status, res_action};

endmodule

FILE: tb/sv/sector_block_cache_controller_unit_tb.sv
module sector_block_cache_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbc_pkg::*;

  // The block under test is built with three blocks of eight sectors, and the
  // cache policy model below uses the same geometry.
  localparam int NBLK         = 3;
  localparam int SPB          = 8;
  localparam int RANDOM_CMDS  = 210;
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int LONG_HOLD    = 200;   // receiver back-pressure burst, in cycles
  localparam int DRAIN_CYCLES = 40;    // several times the slowest write miss
  localparam int PRINT_LIMIT  = 40;

  // One action as the block reports it, with every field unpacked.
  typedef struct packed {
    action_t     action;
    logic [1:0]  blk;
    logic [14:0] fsec;
    logic [2:0]  off;
    logic        status;
    logic        last;
    logic        req_done;
  } flash_action_t;

  // One row of the directed command list. When hand_checked is set, the row
  // carries its single expected action instead of taking the model's.
  typedef struct packed {
    cmd_t        cmd;
    logic [14:0] sec;
    logic        fin;
    logic        hand_checked;
    action_t     act;
    logic [14:0] fsec;
    logic        status;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [14:0] sector, [15] zero fill
  logic [1:0]  s_axis_tuser;   // [1:0] cmd
  logic        s_axis_tlast;   // final_sector
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [1:0] block, [16:2] flash_sector, [19:17] offset,
                               // [23:20] zero fill
  logic [4:0]  m_axis_tuser;   // [2:0] action, [3] status, [4] request_done
  logic        m_axis_tlast;   // last action of the command

  sector_block_cache_controller_unit #(
    .NUM_BLOCKS       (NBLK),
    .SECTORS_PER_BLOCK(SPB)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the cache tags, kept in step with every accepted command.
  logic          cache_valid [NBLK];
  logic          cache_dirty [NBLK];
  logic [14:0]   cache_base  [NBLK];

  // Actions worked out for the command just accepted, and the queue of actions
  // still owed by the block, oldest first.
  flash_action_t staged [4];
  int            staged_n;
  flash_action_t owed_actions [$];
  cmd_row_t      directed_rows [$];

  int  err_count      = 0;
  int  cmds_sent      = 0;
  int  actions_seen   = 0;
  int  idle_cycles    = 0;
  int  kind_count [6] = '{0, 0, 0, 0, 0, 0};
  bit  tx_steady      = 1'b0;
  bit  rx_steady      = 1'b0;
  bit  rx_hold_request = 1'b0;

  function automatic void stage_action(action_t act, int blk, logic [14:0] fsec, int off,
                                       logic st);
    flash_action_t a;
    a.action   = act;
    a.blk      = blk[1:0];
    a.fsec     = fsec;
    a.off      = off[2:0];
    a.status   = st;
    a.last     = 1'b0;
    a.req_done = 1'b0;
    staged[staged_n] = a;
    staged_n++;
  endfunction

  // Cache policy model: fills staged[] with the actions one command causes and
  // updates the shadow tags the way the block is meant to.
  function automatic void predict_cache_actions(cmd_t c, logic [14:0] sec, logic fin);
    int          i;
    int          slot;
    int          best;
    logic [14:0] base;
    staged_n = 0;
    slot     = -1;
    // A block covers the sector when the sector falls in its eight-sector span.
    for (i = 0; i < NBLK; i++) begin
      if (slot < 0 && cache_valid[i] && int'(sec) >= int'(cache_base[i]) &&
          int'(sec) < int'(cache_base[i]) + SPB)
        slot = i;
    end
    case (c)
      CMD_READ: begin
        // A read miss goes straight to flash and allocates nothing.
        if (slot >= 0)
          stage_action(ACT_CREAD, slot, sec, int'(sec) - int'(cache_base[slot]), STATUS_OK);
        else
          stage_action(ACT_FREAD, 0, sec, 0, STATUS_OK);
      end
      CMD_WRITE: begin
        if (slot < 0) begin
          base = 15'(int'(sec) - (int'(sec) % SPB));
          for (i = 0; i < NBLK; i++) begin
            if (slot < 0 && !cache_valid[i])
              slot = i;
          end
          if (slot < 0) begin
            // All blocks are in use: the victim is the first one holding the
            // strictly highest boundary. Only a dirty victim is written back.
            best = 0;
            slot = 0;
            for (i = 0; i < NBLK; i++) begin
              if (int'(cache_base[i]) > best) begin
                best = int'(cache_base[i]);
                slot = i;
              end
            end
            if (cache_dirty[slot])
              stage_action(ACT_WBACK, slot, cache_base[slot], 0, STATUS_OK);
          end
          cache_base[slot]  = base;
          cache_valid[slot] = 1'b1;
          cache_dirty[slot] = 1'b0;
          stage_action(ACT_FILL, slot, base, 0, STATUS_OK);
        end
        stage_action(ACT_CWRITE, slot, sec, int'(sec) - int'(cache_base[slot]), STATUS_OK);
        cache_dirty[slot] = 1'b1;
      end
      CMD_SYNC: begin
        // Every dirty block goes back to flash in index order.
        for (i = 0; i < NBLK; i++) begin
          if (cache_dirty[i]) begin
            stage_action(ACT_WBACK, i, cache_base[i], 0, STATUS_OK);
            cache_dirty[i] = 1'b0;
          end
        end
        stage_action(ACT_DONE, 0, '0, 0, STATUS_OK);
      end
      default: begin
        stage_action(ACT_DONE, 0, '0, 0, STATUS_PARAM_ERR);
      end
    endcase
    staged[staged_n-1].last     = 1'b1;
    staged[staged_n-1].req_done = fin;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("[%0t] action transaction %0d: %s is %0d, expected %0d",
               $time, actions_seen, field, got, want);
  endtask

  task automatic add_row(cmd_t c, logic [14:0] sec, logic fin, logic hand_checked,
                         action_t act, logic [14:0] fsec, logic st);
    cmd_row_t row;
    row.cmd          = c;
    row.sec          = sec;
    row.fin          = fin;
    row.hand_checked = hand_checked;
    row.act          = act;
    row.fsec         = fsec;
    row.status       = st;
    directed_rows.push_back(row);
  endtask

  // Offers one command after a random gap and books the actions it owes once
  // the command transaction is taken. With a zero gap, tvalid simply stays high.
  task automatic send_cmd(cmd_row_t row);
    int            gap;
    int            i;
    flash_action_t a;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, row.sec};
    s_axis_tuser  <= row.cmd;
    s_axis_tlast  <= row.fin;
    do @(posedge clk); while (!s_axis_tready);
    predict_cache_actions(row.cmd, row.sec, row.fin);
    if (row.hand_checked) begin
      a.action   = row.act;
      a.blk      = 2'd0;
      a.fsec     = row.fsec;
      a.off      = 3'd0;
      a.status   = row.status;
      a.last     = 1'b1;
      a.req_done = row.fin;
      owed_actions.push_back(a);
    end else begin
      for (i = 0; i < staged_n; i++)
        owed_actions.push_back(staged[i]);
    end
    cmds_sent++;
  endtask

  // Drops tvalid and waits until every owed action has come back.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (owed_actions.size() != 0);
  endtask

  // Command side: directed list first, then random traffic clustered around a
  // moving hot region so that hits, fills and evictions all happen often.
  initial begin : command_source
    cmd_row_t    row;
    logic [14:0] hot_base;
    int          r;
    int          k;
    int          i;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_READ;
    s_axis_tlast  <= 1'b0;
    for (i = 0; i < NBLK; i++) begin
      cache_valid[i] = 1'b0;
      cache_dirty[i] = 1'b0;
      cache_base[i]  = '0;
    end

    // Right after reset nothing is cached, so reads go to flash and a sync has
    // nothing to write back.
    add_row(CMD_READ,  15'd0,     1'b1, 1'b1, ACT_FREAD, 15'd0,     STATUS_OK);
    add_row(CMD_READ,  15'h7fff,  1'b0, 1'b1, ACT_FREAD, 15'h7fff,  STATUS_OK);
    add_row(CMD_OTHER, 15'd5,     1'b1, 1'b1, ACT_DONE,  15'd0,     STATUS_PARAM_ERR);
    add_row(CMD_SYNC,  15'd0,     1'b0, 1'b1, ACT_DONE,  15'd0,     STATUS_OK);
    // Fill all three blocks, including the top and bottom of the sector range.
    add_row(CMD_WRITE, 15'h7fff,  1'b1, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    add_row(CMD_WRITE, 15'd0,     1'b0, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    add_row(CMD_WRITE, 15'd13,    1'b1, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    // Hits at both ends of a block, a near miss, and a write hit.
    add_row(CMD_READ,  15'd32760, 1'b0, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    add_row(CMD_READ,  15'd15,    1'b1, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    add_row(CMD_READ,  15'd16,    1'b0, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    add_row(CMD_WRITE, 15'd5,     1'b0, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    // Sync with every block dirty gives the longest action burst.
    add_row(CMD_SYNC,  15'd0,     1'b1, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    // Clean eviction of the top block, then a dirty eviction.
    add_row(CMD_WRITE, 15'd100,   1'b0, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    add_row(CMD_WRITE, 15'd200,   1'b1, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    add_row(CMD_OTHER, 15'h7fff,  1'b0, 1'b1, ACT_DONE,  15'd0,     STATUS_PARAM_ERR);
    add_row(CMD_WRITE, 15'd8,     1'b0, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    // Alternating bit patterns on the sector field.
    add_row(CMD_READ,  15'h5555,  1'b1, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    add_row(CMD_WRITE, 15'h2aaa,  1'b0, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    add_row(CMD_SYNC,  15'd0,     1'b0, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);
    // A second sync right after finds nothing dirty.
    add_row(CMD_SYNC,  15'd0,     1'b1, 1'b1, ACT_DONE,  15'd0,     STATUS_OK);
    add_row(CMD_READ,  15'h2aaf,  1'b0, 1'b0, ACT_DONE,  15'd0,     STATUS_OK);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[n])
      send_cmd(directed_rows[n]);
    // The sender sits idle here until the block has answered everything.
    wait_for_drain();

    hot_base = 15'($urandom_range(0, 32767));
    for (k = 0; k < RANDOM_CMDS; k++) begin
      if (k % 30 == 29)
        tx_steady = !tx_steady;
      // Long receiver hold while commands keep coming, so the block backs up.
      if (k == 45)
        rx_hold_request = 1'b1;
      if (k == 120)
        wait_for_drain();
      if ($urandom_range(0, 15) == 0)
        hot_base = 15'($urandom_range(0, 32767));
      r = $urandom_range(0, 99);
      if (r < 35)
        row.cmd = CMD_READ;
      else if (r < 80)
        row.cmd = CMD_WRITE;
      else if (r < 92)
        row.cmd = CMD_SYNC;
      else
        row.cmd = CMD_OTHER;
      // Most sectors fall in a window of four blocks, so three cache blocks
      // keep thrashing; the rest are scattered over the whole range.
      if ($urandom_range(0, 4) == 0)
        row.sec = 15'($urandom_range(0, 32767));
      else
        row.sec = 15'(hot_base + $urandom_range(0, 31));
      row.fin          = 1'($urandom_range(0, 1));
      row.hand_checked = 1'b0;
      row.act          = ACT_DONE;
      row.fsec         = '0;
      row.status       = STATUS_OK;
      send_cmd(row);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands (%0d directed), %0d actions: %0d cache reads, %0d flash reads,",
             cmds_sent, directed_rows.size(), actions_seen, kind_count[0], kind_count[1]);
    $display("  %0d cache writes, %0d writebacks, %0d fills and %0d completions.",
             kind_count[2], kind_count[3], kind_count[4], kind_count[5]);
    if (err_count == 0 && owed_actions.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Action side: a random stall before each transaction, stretches with no
  // stall at all, and one long hold when the command side asks for it.
  initial begin : action_sink
    int stall;
    int served;
    served = 0;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (rx_hold_request) begin
        stall           = LONG_HOLD;
        rx_hold_request = 1'b0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 14);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      served++;
      if (served % 25 == 0)
        rx_steady = !rx_steady;
    end
  end

  // Checker and watchdog. Every action transaction is matched against the
  // oldest owed action, field by field.
  always @(posedge clk) begin : action_check
    flash_action_t want;
    if (rst !== 1'b1) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles, %0d actions still owed",
                 $time, idle_cycles, owed_actions.size());
        $display("DONE: errors detected");
        $finish;
      end else if (m_axis_tvalid && m_axis_tready) begin
        actions_seen++;
        if (m_axis_tuser[2:0] <= ACT_DONE)
          kind_count[m_axis_tuser[2:0]]++;
        if (owed_actions.size() == 0) begin
          report_mismatch("unexpected action", int'(m_axis_tuser[2:0]), -1);
        end else begin
          want = owed_actions.pop_front();
          if (m_axis_tuser[2:0] !== want.action)
            report_mismatch("action", int'(m_axis_tuser[2:0]), int'(want.action));
          if (m_axis_tdata[1:0] !== want.blk)
            report_mismatch("block", int'(m_axis_tdata[1:0]), int'(want.blk));
          if (m_axis_tdata[16:2] !== want.fsec)
            report_mismatch("flash_sector", int'(m_axis_tdata[16:2]), int'(want.fsec));
          if (m_axis_tdata[19:17] !== want.off)
            report_mismatch("offset", int'(m_axis_tdata[19:17]), int'(want.off));
          if (m_axis_tuser[3] !== want.status)
            report_mismatch("status", int'(m_axis_tuser[3]), int'(want.status));
          if (m_axis_tlast !== want.last)
            report_mismatch("last", int'(m_axis_tlast), int'(want.last));
          if (m_axis_tuser[4] !== want.req_done)
            report_mismatch("request_done", int'(m_axis_tuser[4]), int'(want.req_done));
        end
      end
    end
  end

endmodule

FILE: files.f
rtl/sbc_pkg.sv
rtl/sbc_datapath.sv
rtl/sbc_controller.sv
rtl/sector_block_cache_controller_unit.sv
tb/sv/sector_block_cache_controller_unit_tb.sv
